// File: sv/drone_payload_euler_step_defines.svh
// Assertion macros used by the checker file of the payload Euler step block.
`ifndef DRONE_PAYLOAD_EULER_STEP_DEFINES_SVH
`define DRONE_PAYLOAD_EULER_STEP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define DPES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpes: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define DPES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpes: next-cycle check failed");

`endif

// File: sv/dpes_pkg.sv
// Package: microprogram, control word types and codes of the payload Euler step block.
package dpes_pkg;

   // program length and step counter
   localparam int PROG_LEN = 23;
   localparam int STEP_W   = $clog2(PROG_LEN);
   localparam logic [STEP_W-1:0] STEP_IDLE = '0;
   localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(PROG_LEN - 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SWING_COUPLING  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWING_DAMPING   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWING_STIFFNESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRUST_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SWING_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP       = 3'd5;

   // multiplier operand A: coefficients and step
   localparam logic [2:0] A_CC = 3'd0;
   localparam logic [2:0] A_CD = 3'd1;
   localparam logic [2:0] A_CS = 3'd2;
   localparam logic [2:0] A_TG = 3'd3;
   localparam logic [2:0] A_SG = 3'd4;
   localparam logic [2:0] A_DT = 3'd5;

   // multiplier operand B: input, states and derivatives
   localparam logic [2:0] B_PITCH = 3'd0;
   localparam logic [2:0] B_R     = 3'd1;
   localparam logic [2:0] B_A     = 3'd2;
   localparam logic [2:0] B_V     = 3'd3;
   localparam logic [2:0] B_DV    = 3'd4;
   localparam logic [2:0] B_DR    = 3'd5;

   // full product register operations
   localparam logic [1:0] FP_NOP   = 2'd0;
   localparam logic [1:0] FP_LOAD  = 2'd1;
   localparam logic [1:0] FP_ADDHI = 2'd2;

   // accumulator operations
   localparam logic [2:0] ACC_NOP    = 3'd0;
   localparam logic [2:0] ACC_LOADP  = 3'd1;
   localparam logic [2:0] ACC_ADDP   = 3'd2;
   localparam logic [2:0] ACC_SUBP   = 3'd3;
   localparam logic [2:0] ACC_NEGP   = 3'd4;
   localparam logic [2:0] ACC_LOADST = 3'd5;

   // state loaded into the accumulator
   localparam logic [1:0] ST_P = 2'd0;
   localparam logic [1:0] ST_V = 2'd1;
   localparam logic [1:0] ST_A = 2'd2;
   localparam logic [1:0] ST_R = 2'd3;

   // saturated accumulator write-back target
   localparam logic [2:0] WB_NONE = 3'd0;
   localparam logic [2:0] WB_DV   = 3'd1;
   localparam logic [2:0] WB_DR   = 3'd2;
   localparam logic [2:0] WB_P    = 3'd3;
   localparam logic [2:0] WB_V    = 3'd4;
   localparam logic [2:0] WB_A    = 3'd5;
   localparam logic [2:0] WB_R    = 3'd6;

   // jump conditions
   localparam logic [1:0] JC_NONE     = 2'd0;
   localparam logic [1:0] JC_NO_REQ   = 2'd1;
   localparam logic [1:0] JC_OUT_BUSY = 2'd2;

   typedef struct packed {
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      logic       mul_hi;
      logic [1:0] fp_op;
      logic [2:0] acc_op;
      logic [1:0] st_sel;
      logic [2:0] wb_sel;
   } ctrl_type;

   typedef struct packed {
      ctrl_type          dp;
      logic [1:0]        jmp_cond;
      logic [STEP_W-1:0] jmp_to;
      logic              emit;
      logic              end_prog;
   } ucode_type;

   function automatic ucode_type ucode_word(
      input logic [2:0]        a,
      input logic [2:0]        b,
      input logic              hi,
      input logic [1:0]        fp,
      input logic [2:0]        acc,
      input logic [1:0]        st,
      input logic [2:0]        wb,
      input logic [1:0]        jc,
      input logic [STEP_W-1:0] jt,
      input logic              emit,
      input logic              last
   );
      ucode_type w;
      w.dp.a_sel  = a;
      w.dp.b_sel  = b;
      w.dp.mul_hi = hi;
      w.dp.fp_op  = fp;
      w.dp.acc_op = acc;
      w.dp.st_sel = st;
      w.dp.wb_sel = wb;
      w.jmp_cond  = jc;
      w.jmp_to    = jt;
      w.emit      = emit;
      w.end_prog  = last;
      return w;
   endfunction

   // Microprogram. Each product takes two multiplier passes (low then high half of B),
   // is folded into the full product at the next step and reaches the accumulator after that.
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         // wait for a request
         5'd0:  w = ucode_word(A_CC, B_PITCH, 1'b0, FP_NOP, ACC_NOP, ST_P, WB_NONE,
                               JC_NO_REQ, STEP_IDLE, 1'b0, 1'b0);
         // dv = coupling*r + thrust*pitch
         5'd1:  w = ucode_word(A_CC, B_R, 1'b0, FP_NOP, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd2:  w = ucode_word(A_CC, B_R, 1'b1, FP_LOAD, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd3:  w = ucode_word(A_TG, B_PITCH, 1'b0, FP_ADDHI, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd4:  w = ucode_word(A_TG, B_PITCH, 1'b1, FP_LOAD, ACC_LOADP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         // dr = -stiffness*a - damping*r + swing*pitch
         5'd5:  w = ucode_word(A_CS, B_A, 1'b0, FP_ADDHI, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd6:  w = ucode_word(A_CS, B_A, 1'b1, FP_LOAD, ACC_ADDP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd7:  w = ucode_word(A_CD, B_R, 1'b0, FP_ADDHI, ACC_NOP, ST_P, WB_DV,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd8:  w = ucode_word(A_CD, B_R, 1'b1, FP_LOAD, ACC_NEGP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd9:  w = ucode_word(A_SG, B_PITCH, 1'b0, FP_ADDHI, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd10: w = ucode_word(A_SG, B_PITCH, 1'b1, FP_LOAD, ACC_SUBP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         // state updates, each old state plus dt times its rate
         5'd11: w = ucode_word(A_DT, B_V, 1'b0, FP_ADDHI, ACC_NOP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd12: w = ucode_word(A_DT, B_V, 1'b1, FP_LOAD, ACC_ADDP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd13: w = ucode_word(A_DT, B_DV, 1'b0, FP_ADDHI, ACC_LOADST, ST_P, WB_DR,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd14: w = ucode_word(A_DT, B_DV, 1'b1, FP_LOAD, ACC_ADDP, ST_P, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd15: w = ucode_word(A_DT, B_R, 1'b0, FP_ADDHI, ACC_LOADST, ST_V, WB_P,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd16: w = ucode_word(A_DT, B_R, 1'b1, FP_LOAD, ACC_ADDP, ST_V, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd17: w = ucode_word(A_DT, B_DR, 1'b0, FP_ADDHI, ACC_LOADST, ST_A, WB_V,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd18: w = ucode_word(A_DT, B_DR, 1'b1, FP_LOAD, ACC_ADDP, ST_A, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd19: w = ucode_word(A_CC, B_PITCH, 1'b0, FP_ADDHI, ACC_LOADST, ST_R, WB_A,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd20: w = ucode_word(A_CC, B_PITCH, 1'b0, FP_NOP, ACC_ADDP, ST_R, WB_NONE,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         5'd21: w = ucode_word(A_CC, B_PITCH, 1'b0, FP_NOP, ACC_NOP, ST_R, WB_R,
                               JC_NONE, STEP_IDLE, 1'b0, 1'b0);
         // hand the new state to the output register once it is free
         5'd22: w = ucode_word(A_CC, B_PITCH, 1'b0, FP_NOP, ACC_NOP, ST_P, WB_NONE,
                               JC_OUT_BUSY, STEP_EMIT, 1'b1, 1'b1);
         default: w = ucode_word(A_CC, B_PITCH, 1'b0, FP_NOP, ACC_NOP, ST_P, WB_NONE,
                                 JC_NONE, STEP_IDLE, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// File: sv/dpes_datapath.sv
// Datapath: configuration, state, shared half-word multiplier, rounding and saturating accumulator.
module dpes_datapath
   import dpes_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_type                     ctrl,
   input  logic                         pitch_ld,
   input  logic signed [WORD_WIDTH-1:0] pitch_in,
   input  logic                         cfg_we,
   input  logic [CSR_IDX_W-1:0]         cfg_index,
   input  logic [WORD_WIDTH-1:0]        cfg_wdata,
   output logic signed [WORD_WIDTH-1:0] state_p,
   output logic signed [WORD_WIDTH-1:0] state_v,
   output logic signed [WORD_WIDTH-1:0] state_a,
   output logic signed [WORD_WIDTH-1:0] state_r
);

   localparam int LO_W   = WORD_WIDTH / 2;
   localparam int HI_W   = WORD_WIDTH - LO_W;
   localparam int CH_W   = HI_W + 1;
   localparam int PROD_W = WORD_WIDTH + CH_W;
   localparam int FP_W   = 2 * WORD_WIDTH;
   localparam int ACC_W  = FP_W + 2;

   localparam longint ONE       = 64'sd1 <<< FRAC_BITS;
   localparam longint RST_QUART = ONE >>> 2;
   localparam longint RST_GRAV  = (981 * ONE + 50) / 100;
   localparam longint RST_DT    = (ONE + 50) / 100;

   localparam logic signed [FP_W-1:0] HALF = FP_W'(ONE >>> 1);
   localparam logic signed [WORD_WIDTH-1:0] SAT_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] SAT_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic signed [WORD_WIDTH-1:0] coupling_ff, damping_ff, stiffness_ff, thrust_ff, swing_ff;
   logic        [WORD_WIDTH-2:0] dt_ff;
   logic signed [WORD_WIDTH-1:0] pitch_ff;
   logic signed [WORD_WIDTH-1:0] p_ff, v_ff, a_ff, r_ff;
   logic signed [WORD_WIDTH-1:0] dv_ff, dr_ff;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [FP_W-1:0]       fp_ff, fp_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;

   logic signed [WORD_WIDTH-1:0] op_a, op_b, st_val, sat_val;
   logic signed [CH_W-1:0]       chunk;
   logic signed [FP_W-1:0]       prod_ext, rp;
   logic signed [ACC_W-1:0]      rp_ext, st_ext;
   logic                         in_range;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff  <= WORD_WIDTH'(RST_QUART);
         damping_ff   <= WORD_WIDTH'(RST_QUART);
         stiffness_ff <= WORD_WIDTH'(RST_GRAV);
         thrust_ff    <= WORD_WIDTH'(RST_GRAV);
         swing_ff     <= WORD_WIDTH'(RST_GRAV);
         dt_ff        <= (WORD_WIDTH-1)'(RST_DT);
      end else if (cfg_we) begin
         unique case (cfg_index)
            REG_SWING_COUPLING:  coupling_ff  <= cfg_wdata;
            REG_SWING_DAMPING:   damping_ff   <= cfg_wdata;
            REG_SWING_STIFFNESS: stiffness_ff <= cfg_wdata;
            REG_THRUST_GAIN:     thrust_ff    <= cfg_wdata;
            REG_SWING_GAIN:      swing_ff     <= cfg_wdata;
            REG_TIME_STEP:       dt_ff        <= cfg_wdata[WORD_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   // operand selection
   always_comb begin
      unique case (ctrl.a_sel)
         A_CC:    op_a = coupling_ff;
         A_CD:    op_a = damping_ff;
         A_CS:    op_a = stiffness_ff;
         A_TG:    op_a = thrust_ff;
         A_SG:    op_a = swing_ff;
         A_DT:    op_a = $signed({1'b0, dt_ff});
         default: op_a = '0;
      endcase
      unique case (ctrl.b_sel)
         B_PITCH: op_b = pitch_ff;
         B_R:     op_b = r_ff;
         B_A:     op_b = a_ff;
         B_V:     op_b = v_ff;
         B_DV:    op_b = dv_ff;
         B_DR:    op_b = dr_ff;
         default: op_b = '0;
      endcase
   end

   // half of B per pass: low half unsigned, high half signed
   always_comb begin
      if (ctrl.mul_hi) begin
         chunk = $signed({op_b[WORD_WIDTH-1], op_b[WORD_WIDTH-1:LO_W]});
      end else begin
         chunk = $signed({{(CH_W-LO_W){1'b0}}, op_b[LO_W-1:0]});
      end
   end

   assign prod_in = op_a * chunk;

   // fold both passes into the full product, rounding offset added on the first
   assign prod_ext = $signed({{(FP_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});

   always_comb begin
      unique case (ctrl.fp_op)
         FP_LOAD:  fp_in = prod_ext + HALF;
         FP_ADDHI: fp_in = fp_ff + (prod_ext <<< LO_W);
         default:  fp_in = fp_ff;
      endcase
   end

   // rounded product and accumulator
   assign rp     = fp_ff >>> FRAC_BITS;
   assign rp_ext = $signed({{(ACC_W-FP_W){rp[FP_W-1]}}, rp});

   always_comb begin
      unique case (ctrl.st_sel)
         ST_P: st_val = p_ff;
         ST_V: st_val = v_ff;
         ST_A: st_val = a_ff;
         ST_R: st_val = r_ff;
      endcase
   end

   assign st_ext = $signed({{(ACC_W-WORD_WIDTH){st_val[WORD_WIDTH-1]}}, st_val});

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_LOADP:  acc_in = rp_ext;
         ACC_ADDP:   acc_in = acc_ff + rp_ext;
         ACC_SUBP:   acc_in = acc_ff - rp_ext;
         ACC_NEGP:   acc_in = ACC_W'(0) - rp_ext;
         ACC_LOADST: acc_in = st_ext;
         default:    acc_in = acc_ff;
      endcase
   end

   // clamp the accumulator to the signed word range
   assign in_range = (&acc_ff[ACC_W-1:WORD_WIDTH-1]) | ~(|acc_ff[ACC_W-1:WORD_WIDTH-1]);

   always_comb begin
      priority if (in_range) begin
         sat_val = acc_ff[WORD_WIDTH-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_val = SAT_MIN;
      end else begin
         sat_val = SAT_MAX;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      fp_ff   <= fp_in;
      acc_ff  <= acc_in;
      if (pitch_ld) begin
         pitch_ff <= pitch_in;
      end
      if (ctrl.wb_sel == WB_DV) begin
         dv_ff <= sat_val;
      end
      if (ctrl.wb_sel == WB_DR) begin
         dr_ff <= sat_val;
      end
   end

   // plant state
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
         v_ff <= '0;
         a_ff <= '0;
         r_ff <= '0;
      end else begin
         if (ctrl.wb_sel == WB_P) begin
            p_ff <= sat_val;
         end
         if (ctrl.wb_sel == WB_V) begin
            v_ff <= sat_val;
         end
         if (ctrl.wb_sel == WB_A) begin
            a_ff <= sat_val;
         end
         if (ctrl.wb_sel == WB_R) begin
            r_ff <= sat_val;
         end
      end
   end

   assign state_p = p_ff;
   assign state_v = v_ff;
   assign state_a = a_ff;
   assign state_r = r_ff;

endmodule

// File: sv/drone_payload_euler_step.sv
// Top level: microcoded forward-Euler step of the drone with slung load, with output register.
//
// Each accepted beat on req_ carries one pitch command and yields one beat on rsp_ with the
// updated position, velocity, swing angle and swing rate (signed fixed point, FRAC_BITS
// fraction bits, saturated at the word limits). A 23-step microprogram drives nine rounded
// products through one shared multiplier of WORD_WIDTH by WORD_WIDTH/2+1 bits, two passes
// per product, into a single accumulator. The result is loaded into the output register at
// the last step, after which the sequencer wraps to its first step and can accept the next
// beat, so only one item is in work at a time. req_stall is low only
// while the sequencer waits at its first step; the output register lets the next item be
// accepted while a result is still held by rsp_stall, and the sequencer only pauses at its
// last step if the previous result has not been taken. csr_ready is always high; write the
// registers while the block is idle.
module drone_payload_euler_step
   import dpes_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_WIDTH-1:0] req_pitch_command,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_position_out,
   output logic signed [WORD_WIDTH-1:0] rsp_velocity_out,
   output logic signed [WORD_WIDTH-1:0] rsp_angle_out,
   output logic signed [WORD_WIDTH-1:0] rsp_angle_rate_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [WORD_WIDTH-1:0]        csr_wdata
);

   logic [STEP_W-1:0]            step_ff, step_in;
   ucode_type                    uw;
   logic                         accept, out_busy, jump, emit;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_WIDTH-1:0] pos_ff, vel_ff, ang_ff, rate_ff;
   logic signed [WORD_WIDTH-1:0] state_p, state_v, state_a, state_r;

   // fetch the control word of the current step
   assign uw = ucode(step_ff);

   assign req_stall = (step_ff != STEP_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit      = uw.emit && !out_busy;
   assign csr_ready = 1'b1;

   // sequencer: conditional jump, else advance or wrap to the first step
   always_comb begin
      unique case (uw.jmp_cond)
         JC_NO_REQ:   jump = !req_valid;
         JC_OUT_BUSY: jump = out_busy;
         default:     jump = 1'b0;
      endcase
      priority if (jump) begin
         step_in = uw.jmp_to;
      end else if (uw.end_prog) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   dpes_datapath #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (uw.dp),
      .pitch_ld  (accept),
      .pitch_in  (req_pitch_command),
      .cfg_we    (csr_valid),
      .cfg_index (csr_index),
      .cfg_wdata (csr_wdata),
      .state_p   (state_p),
      .state_v   (state_v),
      .state_a   (state_a),
      .state_r   (state_r)
   );

   // output register: hold while stalled, drop once the beat is taken
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pos_ff  <= state_p;
         vel_ff  <= state_v;
         ang_ff  <= state_a;
         rate_ff <= state_r;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_out   = pos_ff;
   assign rsp_velocity_out   = vel_ff;
   assign rsp_angle_out      = ang_ff;
   assign rsp_angle_rate_out = rate_ff;

endmodule

// File: sv/dpes_checker.sv
// Checker on the top-level ports of the payload Euler step block, bound to the top level.
`include "drone_payload_euler_step_defines.svh"

module dpes_checker #(
   parameter int WORD_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [WORD_WIDTH-1:0] rsp_position_out
);

   // reset empties the output register
   `DPES_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

   // one item at a time: an accepted beat closes the request side
   `DPES_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a result only appears at the end of work on an item
   `DPES_ASSERT_NOW(a_result_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // a stalled result holds
   `DPES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_position_out))

endmodule

bind drone_payload_euler_step dpes_checker #(.WORD_WIDTH(WORD_WIDTH)) u_dpes_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the drone payload forward-Euler step block.
module testbench;
   import dpes_pkg::*;

   localparam int WORD = 32;
   localparam int FRAC = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 30;

   // indexes that map to no register
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

   typedef logic signed [WORD-1:0] word_type;

   typedef struct {
      word_type position;
      word_type velocity;
      word_type angle;
      word_type angle_rate;
   } plant_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [WORD-1:0]   req_pitch_command = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   word_type          rsp_position_out;
   word_type          rsp_velocity_out;
   word_type          rsp_angle_out;
   word_type          rsp_angle_rate_out;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD-1:0]   csr_wdata = '0;

   // shadow copy of the coefficient registers, reset values
   word_type    coupling_q   = 32'sd16384;
   word_type    damping_q    = 32'sd16384;
   word_type    stiffness_q  = 32'sd642908;
   word_type    thrust_q     = 32'sd642908;
   word_type    swing_gain_q = 32'sd642908;
   logic [30:0] step_q       = 31'd655;

   plant_state_type plant_now = '{default: '0};
   plant_state_type expected_states[$];
   logic [WORD-1:0] pitch_queue[$];

   int items_issued   = 0;
   int results_taken  = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int req_gap        = 0;
   int stall_left     = 0;
   logic req_accepted = 1'b0;
   logic steady_flow  = 1'b0;

   drone_payload_euler_step DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pitch_command  (req_pitch_command),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_out   (rsp_position_out),
      .rsp_velocity_out   (rsp_velocity_out),
      .rsp_angle_out      (rsp_angle_out),
      .rsp_angle_rate_out (rsp_angle_rate_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact product brought back to FRAC fraction bits, ties rounded upwards
   function automatic logic signed [63:0] rounded_product(input logic signed [63:0] lhs,
                                                          input logic signed [63:0] rhs);
      logic signed [63:0] exact;
      exact = lhs * rhs;
      return (exact + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic word_type clamp_word(input logic signed [63:0] v);
      if (v > WORD_MAX) return WORD_MAX[WORD-1:0];
      if (v < WORD_MIN) return WORD_MIN[WORD-1:0];
      return v[WORD-1:0];
   endfunction

   // one Euler tick: every new state is built from the old ones only
   function automatic plant_state_type euler_update(input plant_state_type old,
                                                    input word_type pitch);
      logic signed [63:0] dt_ext;
      logic signed [63:0] dv_sum;
      logic signed [63:0] dr_sum;
      word_type dv;
      word_type dr;
      plant_state_type nxt;
      dt_ext = $signed({33'd0, step_q});
      dv_sum = rounded_product(coupling_q, old.angle_rate) + rounded_product(thrust_q, pitch);
      dr_sum = rounded_product(swing_gain_q, pitch)
             - rounded_product(stiffness_q, old.angle)
             - rounded_product(damping_q, old.angle_rate);
      dv = clamp_word(dv_sum);
      dr = clamp_word(dr_sum);
      nxt.position   = clamp_word(old.position + rounded_product(dt_ext, old.velocity));
      nxt.velocity   = clamp_word(old.velocity + rounded_product(dt_ext, dv));
      nxt.angle      = clamp_word(old.angle + rounded_product(dt_ext, old.angle_rate));
      nxt.angle_rate = clamp_word(old.angle_rate + rounded_product(dt_ext, dr));
      return nxt;
   endfunction

   function automatic void check_field(input string label, input word_type want,
                                       input word_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                  $time, label, want, want, got, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [WORD-1:0] pick_coeff();
      logic [WORD-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = 32'h0000_0000;
         3: v = $urandom;
         default: begin
            v = $urandom_range(0, 20 * 65536);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   // the top bit is outside the step register and must be dropped
   function automatic logic [WORD-1:0] pick_step();
      logic [WORD-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'hFFFF_FFFF;
         1: v = 32'h0000_0000;
         2: v = $urandom;
         default: v = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 3000))};
      endcase
      return v;
   endfunction

   function automatic logic [WORD-1:0] pick_pitch();
      logic [WORD-1:0] v;
      case ($urandom_range(0, 7))
         0: v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1, 2: v = $urandom;
         default: begin
            v = $urandom_range(0, 2 * 65536);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [WORD-1:0] data);
      case (idx)
         REG_SWING_COUPLING:  coupling_q   = data;
         REG_SWING_DAMPING:   damping_q    = data;
         REG_SWING_STIFFNESS: stiffness_q  = data;
         REG_THRUST_GAIN:     thrust_q     = data;
         REG_SWING_GAIN:      swing_gain_q = data;
         REG_TIME_STEP:       step_q       = data[30:0];
         default: ;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_plant(input logic [WORD-1:0] coupling, input logic [WORD-1:0] damping,
                                input logic [WORD-1:0] stiffness, input logic [WORD-1:0] thrust,
                                input logic [WORD-1:0] swing, input logic [WORD-1:0] step);
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SWING_COUPLING, coupling);
      write_reg(REG_SWING_DAMPING, damping);
      write_reg(REG_SWING_STIFFNESS, stiffness);
      write_reg(REG_THRUST_GAIN, thrust);
      write_reg(REG_SWING_GAIN, swing);
      write_reg(REG_TIME_STEP, step);
      write_reg(REG_SPARE_HI, $urandom);
   endtask

   task automatic queue_pitch(input logic [WORD-1:0] pitch);
      pitch_queue.push_back(pitch);
      items_issued++;
   endtask

   task automatic wait_idle();
      while (results_taken != items_issued) @(negedge clock);
   endtask

   // predict on every accepted pitch beat
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         plant_now = euler_update(plant_now, req_pitch_command);
         expected_states.push_back(plant_now);
      end
   end

   // drive pitch beats, hold while stalled, idle in random bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         req_valid <= 1'b1;
      end else if (req_gap != 0) begin
         req_gap   <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pitch_queue.size() != 0 && (steady_flow || $urandom_range(0, 11) != 0)) begin
         req_valid         <= 1'b1;
         req_pitch_command <= pitch_queue.pop_front();
      end else begin
         req_valid <= 1'b0;
         if (pitch_queue.size() != 0) req_gap <= $urandom_range(0, 10);
      end
   end

   // stall the result channel in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_states.size() == 0) begin
            $display("%0t: unexpected result, expected none, got position %0d", $time,
                     rsp_position_out);
            mismatch_count++;
         end else begin
            plant_state_type want;
            want = expected_states.pop_front();
            check_field("position_out", want.position, rsp_position_out);
            check_field("velocity_out", want.velocity, rsp_velocity_out);
            check_field("angle_out", want.angle, rsp_angle_out);
            check_field("angle_rate_out", want.angle_rate, rsp_angle_rate_out);
            results_taken++;
         end
      end
   end

   // end the run if no channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, unit steps, ties on the rounding, extremes and bit patterns
      queue_pitch(32'h0000_0000); queue_pitch(32'h0000_0001); queue_pitch(32'hFFFF_FFFF);
      queue_pitch(32'h0001_0000); queue_pitch(32'hFFFF_0000); queue_pitch(32'h0000_8000);
      queue_pitch(32'hFFFF_8000); queue_pitch(32'h0000_FFFF); queue_pitch(32'hFFFF_0001);
      queue_pitch(32'h7FFF_FFFF); queue_pitch(32'h7FFF_FFFF); queue_pitch(32'h7FFF_FFFF);
      queue_pitch(32'h8000_0000); queue_pitch(32'h8000_0000); queue_pitch(32'h8000_0000);
      queue_pitch(32'h5555_5555); queue_pitch(32'hAAAA_AAAA); queue_pitch(32'h0000_0000);
      queue_pitch(32'h0000_0000); queue_pitch(32'h0000_0000);
      repeat (60) queue_pitch(pick_pitch());
      wait_idle();

      // random coefficient sets, extremes among the choices
      for (phase = 0; phase < 5; phase++) begin
         program_plant(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                       pick_step());
         repeat (50) queue_pitch(pick_pitch());
         wait_idle();
      end

      // largest step and extreme gains: drive every state into saturation
      program_plant(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF);
      repeat (40) queue_pitch(pick_pitch());
      wait_idle();

      // opposite extremes at unit step, both channels flowing freely
      program_plant(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8001_0000);
      @(posedge clock);
      steady_flow = 1'b1;
      repeat (40) queue_pitch(pick_pitch());
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_states.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_states.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
